FILE: src/cap_pkg.sv
package cap_pkg;

  // A ray can run at most seven squares, so seven ray cells finish any slider.
  localparam int unsigned NumRayCells = 7;
  localparam int unsigned NumRays     = 4;

  localparam logic [63:0] FileA  = 64'h0101_0101_0101_0101;
  localparam logic [63:0] FileH  = 64'h8080_8080_8080_8080;
  localparam logic [63:0] FileAB = 64'h0303_0303_0303_0303;
  localparam logic [63:0] FileGH = 64'hC0C0_C0C0_C0C0_C0C0;

  typedef enum logic [2:0] {
    KIND_WPAWN  = 3'd0,
    KIND_BPAWN  = 3'd1,
    KIND_KNIGHT = 3'd2,
    KIND_KING   = 3'd3,
    KIND_BISHOP = 3'd4,
    KIND_ROOK   = 3'd5
  } cap_kind_t;

  // One query on its way down the chain. Each frontier holds at most one
  // square: the ray's current tip, cleared once the ray has hit a piece.
  typedef struct packed {
    logic                             rook;
    logic [63:0]                      occupancy;
    logic [NumRays-1:0][63:0]         frontier;
    logic [63:0]                      attack;
  } cap_item_t;

  // Moves a board one step along a ray, dropping squares that wrap a file.
  // Bishop rays are +9, +7, -7, -9; rook rays are +8, +1, -1, -8.
  function automatic logic [63:0] ray_shift(input logic [63:0] bb,
                                            input logic [1:0]  dir,
                                            input logic        rook);
    logic [63:0] res;
    res = '0;
    if (rook) begin
      case (dir)
        2'd0:    res = bb << 8;
        2'd1:    res = (bb << 1) & ~FileA;
        2'd2:    res = (bb >> 1) & ~FileH;
        2'd3:    res = bb >> 8;
        default: res = '0;
      endcase
    end else begin
      case (dir)
        2'd0:    res = (bb << 9) & ~FileA;
        2'd1:    res = (bb << 7) & ~FileH;
        2'd2:    res = (bb >> 7) & ~FileA;
        2'd3:    res = (bb >> 9) & ~FileH;
        default: res = '0;
      endcase
    end
    return res;
  endfunction

endpackage

FILE: src/cap_entry.sv
module cap_entry import cap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  input  logic [2:0]  func,
  input  logic [5:0]  square,
  input  logic [63:0] occupancy,
  output logic        up_stall,
  output logic        dn_valid,
  output cap_item_t   dn_item,
  input  logic        dn_stall
);

  logic        valid;
  cap_item_t   item;
  cap_item_t   item_next;
  logic [63:0] origin;

  assign origin   = 64'd1 << square;
  assign up_stall = valid & dn_stall;
  assign dn_valid = valid;
  assign dn_item  = item;

  // Leapers get their whole set here; sliders start every ray at the origin.
  always_comb begin
    item_next           = '0;
    item_next.occupancy = occupancy;
    case (cap_kind_t'(func))
      KIND_WPAWN: begin
        item_next.attack = ((origin << 9) & ~FileA) | ((origin << 7) & ~FileH);
      end
      KIND_BPAWN: begin
        item_next.attack = ((origin >> 7) & ~FileA) | ((origin >> 9) & ~FileH);
      end
      KIND_KNIGHT: begin
        item_next.attack = ((origin << 17) & ~FileA)  | ((origin << 15) & ~FileH)
                         | ((origin << 10) & ~FileAB) | ((origin << 6)  & ~FileGH)
                         | ((origin >> 6)  & ~FileAB) | ((origin >> 10) & ~FileGH)
                         | ((origin >> 15) & ~FileA)  | ((origin >> 17) & ~FileH);
      end
      KIND_KING: begin
        item_next.attack = ((origin << 9) & ~FileA) | (origin << 8)
                         | ((origin << 7) & ~FileH) | ((origin << 1) & ~FileA)
                         | ((origin >> 1) & ~FileH) | ((origin >> 7) & ~FileA)
                         | (origin >> 8)            | ((origin >> 9) & ~FileH);
      end
      KIND_BISHOP: begin
        item_next.frontier = {NumRays{origin}};
      end
      KIND_ROOK: begin
        item_next.rook     = 1'b1;
        item_next.frontier = {NumRays{origin}};
      end
      default: item_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      item <= item_next;
    end
  end

endmodule

FILE: src/cap_ray_cell.sv
module cap_ray_cell import cap_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  input  cap_item_t up_item,
  output logic      up_stall,
  output logic      dn_valid,
  output cap_item_t dn_item,
  input  logic      dn_stall
);

  logic                     valid;
  cap_item_t                item;
  cap_item_t                item_next;
  logic [NumRays-1:0][63:0] stepped;

  assign up_stall = valid & dn_stall;
  assign dn_valid = valid;
  assign dn_item  = item;

  // Every ray advances one square. The square reached is attacked; the ray
  // carries on from it only if it is empty.
  always_comb begin
    item_next = up_item;
    for (int d = 0; d < NumRays; d++) begin
      stepped[d]            = ray_shift(up_item.frontier[d], 2'(d), up_item.rook);
      item_next.attack      = item_next.attack | stepped[d];
      item_next.frontier[d] = stepped[d] & ~up_item.occupancy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      item <= item_next;
    end
  end

  // A ray tip is a single square or nothing.
  a_tip_single: assert property (@(posedge clk) disable iff (rst)
    valid |-> ($onehot0(item.frontier[0]) && $onehot0(item.frontier[1]) &&
               $onehot0(item.frontier[2]) && $onehot0(item.frontier[3])))
    else $error("ray tip holds more than one square");

  // A live tip has already been added to the attack set.
  a_tip_attacked: assert property (@(posedge clk) disable iff (rst)
    valid |-> ((item.frontier[0] | item.frontier[1] |
                item.frontier[2] | item.frontier[3]) & ~item.attack) == 64'd0)
    else $error("ray tip missing from attack set");

  // A ray never continues past an occupied square.
  a_tip_blocked: assert property (@(posedge clk) disable iff (rst)
    valid |-> ((item.frontier[0] | item.frontier[1] |
                item.frontier[2] | item.frontier[3]) & item.occupancy) == 64'd0)
    else $error("ray continues through an occupied square");

endmodule

FILE: src/chess_piece_attack_set_unit.sv
// Channel  | Direction | Handshake                   | Payload
// query    | in        | query_valid / query_stall   | func, square, occupancy
// result   | out       | result_valid / result_stall | attack_set
//
// One query is taken every cycle while query_stall is low. Its attack set passes through the entry
// register and then each ray cell register before it stands on the result ports.
// The chain holds one entry stage and seven ray cells, each
// moving every slider ray on by one square; the last cell is the output register.
// Reset (rst, synchronous) empties every stage; no data needs clearing.
// A stall on the result side holds each full stage, and reaches the query
// side only once every stage in between holds a query.

module chess_piece_attack_set_unit import cap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        query_valid,
  output logic        query_stall,
  input  logic [2:0]  func,
  input  logic [5:0]  square,
  input  logic [63:0] occupancy,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] attack_set
);

  // Stage 0 is the entry stage; stage k+1 is the output of ray cell k.
  logic      chain_valid [NumRayCells+1];
  logic      chain_stall [NumRayCells+1];
  cap_item_t chain_item  [NumRayCells+1];

  // The entry stage decodes the piece kind. Leapers leave it finished, and
  // the ray cells then pass them along unchanged since their rays are empty.
  cap_entry u_entry (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (query_valid),
    .func      (func),
    .square    (square),
    .occupancy (occupancy),
    .up_stall  (query_stall),
    .dn_valid  (chain_valid[0]),
    .dn_item   (chain_item[0]),
    .dn_stall  (chain_stall[0])
  );

  // Each ray cell lengthens all four rays of a slider by one square, so a
  // ray of any length up to seven squares is complete at the end of the row.
  for (genvar k = 0; k < NumRayCells; k++) begin : g_cell
    cap_ray_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[k]),
      .up_item  (chain_item[k]),
      .up_stall (chain_stall[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_item  (chain_item[k+1]),
      .dn_stall (chain_stall[k+1])
    );
  end

  // The last cell's register drives the result channel directly.
  assign chain_stall[NumRayCells] = result_stall;
  assign result_valid             = chain_valid[NumRayCells];
  assign attack_set               = chain_item[NumRayCells].attack;

endmodule

FILE: verif/chess_piece_attack_set_unit_tb.sv
module chess_piece_attack_set_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cap_pkg::*;

  // The two piece codes that the block does not use. Any query that carries
  // one of them must come back as an empty attack set.
  localparam logic [2:0] KindSpare6 = 3'd6;
  localparam logic [2:0] KindSpare7 = 3'd7;

  // Shape of the random part of the run.
  localparam int unsigned RandomItems   = 1600;
  localparam int unsigned SqueezeAt     = 200;  // item at which the long hold-off starts
  localparam int unsigned SqueezeItems  = 100;  // items offered back to back meanwhile
  localparam int unsigned SqueezeCycles = 80;   // length of the long hold-off
  localparam int unsigned CalmItems     = 200;  // final items with no idling at all
  localparam int unsigned DrainCycles   = 16;   // idle watch after the last expected result
  localparam int unsigned ReportLimit   = 100;

  // King directions, in file and rank steps. The four diagonals double as
  // the bishop rays and the four orthogonals as the rook rays.
  localparam int KingDf [8] = '{1, 0, -1, 1, -1, 1, 0, -1};
  localparam int KingDr [8] = '{1, 1, 1, 0, 0, -1, -1, -1};
  localparam int KnightDf [8] = '{1, -1, 2, -2, 2, -2, 1, -1};
  localparam int KnightDr [8] = '{2, 2, 1, 1, -1, -1, -2, -2};

  logic        clk;
  logic        rst = 1'b1;
  logic        query_valid = 1'b0;
  logic        query_stall;
  logic [2:0]  func = KIND_WPAWN;
  logic [5:0]  square = '0;
  logic [63:0] occupancy = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [63:0] attack_set;

  // A hand-written expectation travels with the query it belongs to, so that
  // the monitor can pick it up at the very edge at which the transfer happens.
  logic        known_flag = 1'b0;
  logic [63:0] known_value = '0;

  logic [63:0] attack_queue [$];
  logic [63:0] wanted_attack;
  int unsigned fail_count = 0;
  bit          squeeze_req = 1'b0;
  bit          quiet = 1'b0;

  chess_piece_attack_set_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .func         (func),
    .square       (square),
    .occupancy    (occupancy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .attack_set   (attack_set)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A generous ceiling: the slowest legal run is well under a millisecond.
  initial begin
    #5_000_000;
    $display("chess_piece_attack_set_unit verification failed");
    $finish;
  end

  // One square as a board, or an empty board when the square lies off the edge.
  function automatic logic [63:0] square_mask(input int f, input int r);
    logic [63:0] mask;
    mask = '0;
    if (f >= 0 && f < 8 && r >= 0 && r < 8) begin
      mask[r * 8 + f] = 1'b1;
    end
    return mask;
  endfunction

  // Predicts the attack set of one query. Jumping pieces simply collect their
  // on-board targets; sliders walk each ray until they leave the board or have
  // marked the first occupied square. The origin's own bit is never looked at.
  function automatic logic [63:0] attack_of(input logic [2:0] kind, input logic [5:0] sq,
                                            input logic [63:0] occ);
    logic [63:0] set;
    logic [63:0] tip;
    int          f;
    int          r;
    int          nf;
    int          nr;
    bit          diag;
    bit          blocked;
    set = '0;
    f = int'(sq[2:0]);
    r = int'(sq[5:3]);
    case (kind)
      KIND_WPAWN, KIND_BPAWN: begin
        for (int i = 0; i < 2; i++) begin
          set |= square_mask(f + ((i == 0) ? 1 : -1), r + ((kind == KIND_WPAWN) ? 1 : -1));
        end
      end
      KIND_KNIGHT: begin
        for (int i = 0; i < 8; i++) begin
          set |= square_mask(f + KnightDf[i], r + KnightDr[i]);
        end
      end
      KIND_KING: begin
        for (int i = 0; i < 8; i++) begin
          set |= square_mask(f + KingDf[i], r + KingDr[i]);
        end
      end
      KIND_BISHOP, KIND_ROOK: begin
        for (int i = 0; i < 8; i++) begin
          diag = (KingDf[i] != 0) && (KingDr[i] != 0);
          if (diag == (kind == KIND_BISHOP)) begin
            nf = f + KingDf[i];
            nr = r + KingDr[i];
            tip = square_mask(nf, nr);
            blocked = 1'b0;
            while (tip != '0 && !blocked) begin
              set |= tip;
              blocked = |(occ & tip);
              nf += KingDf[i];
              nr += KingDr[i];
              tip = square_mask(nf, nr);
            end
          end
        end
      end
      default: set = '0;
    endcase
    return set;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  // The monitor works on the values that stood just before the edge, so it is
  // blind to the order in which this edge's updates land. Every accepted query
  // queues its expected attack set; every accepted result takes the oldest one.
  always @(posedge clk) begin
    if (!rst) begin
      if (query_valid && !query_stall) begin
        attack_queue.push_back(known_flag ? known_value : attack_of(func, square, occupancy));
      end
      if (result_valid && !result_stall) begin
        if (attack_queue.size() == 0) begin
          report_mismatch("result transfer with no query outstanding", 'x, attack_set);
        end else begin
          wanted_attack = attack_queue.pop_front();
          if (attack_set !== wanted_attack) begin
            report_mismatch("attack_set", wanted_attack, attack_set);
          end
        end
      end
    end
  end

  // Result side. Each cycle settles the stall for the next one, so the signal
  // takes a single update per edge. Short random holds mix with free
  // runs of varying length; once the query side asks for it, one long hold
  // lets the chain fill up until it pushes back on the query side. In the calm
  // final stretch the result side takes everything at once.
  initial begin : result_side
    int unsigned held;
    int unsigned run_left;
    bit          hold;
    held = 0;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        held = SqueezeCycles;
        run_left = 0;
      end
      if (quiet) begin
        hold = 1'b0;
      end else begin
        if (held == 0 && run_left == 0) begin
          if ($urandom_range(0, 2) == 0) begin
            held = $urandom_range(1, 19);
          end else begin
            run_left = $urandom_range(1, 60);
          end
        end
        if (held != 0) begin
          hold = 1'b1;
          held--;
        end else begin
          hold = 1'b0;
          run_left--;
        end
      end
      result_stall <= hold;
    end
  end

  // Offers one query and returns at the edge of its transfer. A gap, when one
  // is taken, comes before the query, so idling falls between transfers and
  // never behind the back of a payload that is already on offer.
  task automatic offer(input logic [2:0] kind, input logic [5:0] sq, input logic [63:0] occ,
                       input logic known, input logic [63:0] value, input bit idle_ok);
    if (idle_ok && !quiet && $urandom_range(0, 3) == 0) begin
      query_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    query_valid <= 1'b1;
    func        <= kind;
    square      <= sq;
    occupancy   <= occ;
    known_flag  <= known;
    known_value <= value;
    do @(posedge clk); while (query_stall);
  endtask

  // Directed queries. Rows with the known flag carry an attack set that can
  // be read straight off the board; the others are left to the predictor.
  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  sq;
    logic [63:0] occ;
    logic        known;
    logic [63:0] want;
  } probe_t;

  localparam int unsigned NumProbes = 23;
  localparam probe_t Probes [NumProbes] = '{
    // Pawns: a white pawn on a1 hits only b2, pawns on their far rank hit nothing.
    '{KIND_WPAWN,  6'd0,  64'd0,                  1'b1, 64'h0000_0000_0000_0200},
    '{KIND_WPAWN,  6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0},
    '{KIND_WPAWN,  6'd56, 64'd0,                  1'b1, 64'd0},
    '{KIND_BPAWN,  6'd0,  64'd0,                  1'b1, 64'd0},
    '{KIND_BPAWN,  6'd7,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0},
    '{KIND_BPAWN,  6'd63, 64'd0,                  1'b1, 64'h0040_0000_0000_0000},
    // Knights and kings in the corners and in the middle of the board.
    '{KIND_KNIGHT, 6'd0,  64'd0,                  1'b1, 64'h0000_0000_0002_0400},
    '{KIND_KNIGHT, 6'd63, 64'd0,                  1'b0, 64'd0},
    '{KIND_KNIGHT, 6'd27, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
    '{KIND_KING,   6'd0,  64'd0,                  1'b1, 64'h0000_0000_0000_0302},
    '{KIND_KING,   6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
    '{KIND_KING,   6'd36, 64'd0,                  1'b0, 64'd0},
    // Sliders on an empty board, a full board and partly blocked boards.
    '{KIND_BISHOP, 6'd0,  64'd0,                  1'b1, 64'h8040_2010_0804_0200},
    '{KIND_BISHOP, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0000_0000_0000_0200},
    '{KIND_BISHOP, 6'd27, 64'h0022_0000_1400_0041, 1'b0, 64'd0},
    '{KIND_ROOK,   6'd0,  64'd0,                  1'b1, 64'h0101_0101_0101_01FE},
    '{KIND_ROOK,   6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0000_0000_0000_0102},
    // An occupied origin must not cut any ray short; in the first row it is the only piece.
    '{KIND_ROOK,   6'd63, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
    '{KIND_ROOK,   6'd35, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},
    '{KIND_BISHOP, 6'd7,  64'h0000_0020_0000_0080, 1'b0, 64'd0},
    '{KIND_ROOK,   6'd28, 64'h0010_0000_1000_0010, 1'b0, 64'd0},
    // The unused piece codes give an empty attack set.
    '{KindSpare6,  6'd27, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0},
    '{KindSpare7,  6'd63, 64'd0,                  1'b1, 64'd0}
  };

  // Query side: reset, the directed table, then random queries. Random boards
  // come in four densities so that slider rays are sometimes long, sometimes
  // cut after one square and sometimes blocked only at a far square.
  initial begin : query_side
    logic [2:0]  kind;
    logic [63:0] occ;
    bit          in_squeeze;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int unsigned k = 0; k < NumProbes; k++) begin
      offer(Probes[k].kind, Probes[k].sq, Probes[k].occ, Probes[k].known, Probes[k].want,
            1'b1);
    end

    for (int unsigned k = 0; k < RandomItems; k++) begin
      if (k == SqueezeAt) begin
        squeeze_req = 1'b1;
      end
      if (k == RandomItems - CalmItems) begin
        quiet = 1'b1;
      end
      in_squeeze = (k >= SqueezeAt) && (k < SqueezeAt + SqueezeItems);

      if ($urandom_range(0, 15) < 14) begin
        kind = 3'($urandom_range(KIND_WPAWN, KIND_ROOK));
      end else begin
        kind = 3'($urandom_range(KindSpare6, KindSpare7));
      end

      case ($urandom_range(0, 3))
        0: occ = {$urandom, $urandom};
        1: occ = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        2: occ = {$urandom, $urandom} | {$urandom, $urandom};
        default: begin
          occ = '0;
          occ[$urandom_range(0, 63)] = 1'($urandom_range(0, 1));
          occ[$urandom_range(0, 63)] = 1'($urandom_range(0, 1));
        end
      endcase

      offer(kind, 6'($urandom_range(0, 63)), occ, 1'b0, '0, !in_squeeze);
    end
    query_valid <= 1'b0;

    // Let every outstanding attack set arrive, then watch a little longer for
    // any stray result transfer before giving the verdict.
    while (attack_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("chess_piece_attack_set_unit verification clean");
    end else begin
      $display("chess_piece_attack_set_unit verification failed");
    end
    $finish;
  end

endmodule
